/* rtl/core/grouped_unique_address_history_defines.svh */
// Assertion macros for the address history block.
`ifndef GROUPED_UNIQUE_ADDRESS_HISTORY_DEFINES_SVH
`define GROUPED_UNIQUE_ADDRESS_HISTORY_DEFINES_SVH

`ifndef SYNTHESIS
`define GUAH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("guah assertion failed");
`define GUAH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("guah assertion failed");
`else
`define GUAH_ASSERT(lbl, prop)
`define GUAH_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* rtl/core/guah_pkg.sv */
package guah_pkg;

  localparam int GROUPS     = 3;
  localparam int LIST_DEPTH = 4;

  localparam int ADDR_W    = 16;
  localparam int IN_GRP_W  = 3;
  localparam int IN_MASK_W = 8;
  localparam int STATUS_W  = 2;

  localparam int GIDX_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int IDX_W  = $clog2(LIST_DEPTH);

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;
  localparam int GRP_LSB     = 0;
  localparam int ADDR_LSB    = GRP_LSB + IN_GRP_W;
  localparam int MASK_LSB    = ADDR_LSB + ADDR_W;

  localparam logic [IN_GRP_W:0] GRP_LIMIT = (IN_GRP_W + 1)'(GROUPS);
  localparam logic [7:0]        FILL_BYTE = 8'hff;
  localparam logic [ADDR_W-1:0] FILL_WORD = {FILL_BYTE, FILL_BYTE};

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ADDED     = 2'd0,
    STAT_PRESENT   = 2'd1,
    STAT_BAD_GROUP = 2'd2,
    STAT_CLEARED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              shift;
    logic              clear;
    logic [GIDX_W-1:0] grp;
    logic [IDX_W-1:0]  idx;
    logic [GROUPS-1:0] mask;
    logic [ADDR_W-1:0] addr;
  } tbl_cmd_t;

endpackage

/* rtl/core/guah_table.sv */
module guah_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  guah_pkg::tbl_cmd_t        cmd,
  output logic [guah_pkg::ADDR_W-1:0] rd_data
);

  logic [guah_pkg::ADDR_W-1:0] tbl_r   [guah_pkg::GROUPS][guah_pkg::LIST_DEPTH];
  logic [guah_pkg::ADDR_W-1:0] tbl_nxt [guah_pkg::GROUPS][guah_pkg::LIST_DEPTH];

  assign rd_data = tbl_r[cmd.grp][cmd.idx];

  always_comb begin
    for (int g = 0; g < guah_pkg::GROUPS; g++) begin
      for (int i = 0; i < guah_pkg::LIST_DEPTH; i++) begin
        tbl_nxt[g][i] = tbl_r[g][i];
      end
      if (cmd.clear && cmd.mask[g]) begin
        for (int i = 0; i < guah_pkg::LIST_DEPTH; i++) begin
          tbl_nxt[g][i] = guah_pkg::FILL_WORD;
        end
      end else if (cmd.shift && (cmd.grp == guah_pkg::GIDX_W'(g))) begin
        // oldest at slot 0, newest at the top
        for (int i = 0; i < guah_pkg::LIST_DEPTH - 1; i++) begin
          tbl_nxt[g][i] = tbl_r[g][i+1];
        end
        tbl_nxt[g][guah_pkg::LIST_DEPTH-1] = cmd.addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < guah_pkg::GROUPS; g++) begin
      for (int i = 0; i < guah_pkg::LIST_DEPTH; i++) begin
        if (!rst_n) begin
          tbl_r[g][i] <= '0;
        end else begin
          tbl_r[g][i] <= tbl_nxt[g][i];
        end
      end
    end
  end

endmodule

/* rtl/core/grouped_unique_address_history.sv */
// Insert: accept, then one compare per list slot until a hit or the last slot
// (through the single shared 16-bit comparator), then finish.
// A clear or an out-of-range group skips the scan. A new item is taken only once
// the last one has finished, and the finish waits on a full output register.
// Result appears the cycle after the finish cycle.
// Synchronous active-low reset zeroes the whole table and empties the output.
`include "grouped_unique_address_history_defines.svh"

module grouped_unique_address_history (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [guah_pkg::IN_TDATA_W-1:0]     in_tdata,   // group, address, clear_mask
  input  logic                                in_tuser,   // operation
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [guah_pkg::OUT_TDATA_W-1:0]    out_tdata   // status
);

  guah_pkg::state_t               state_r, state_nxt;
  logic                           op_r;
  logic [guah_pkg::GIDX_W-1:0]    grp_r;
  logic [guah_pkg::ADDR_W-1:0]    addr_r;
  logic [guah_pkg::GROUPS-1:0]    mask_r;
  logic [guah_pkg::IDX_W-1:0]     idx_r;
  guah_pkg::status_t              stat_r;
  logic                           out_valid_r;
  guah_pkg::status_t              out_status_r;

  guah_pkg::tbl_cmd_t             tbl_cmd;
  logic [guah_pkg::ADDR_W-1:0]    rd_data;
  logic                           in_fire, grp_ok, hit, last, out_free, finish_fire;
  logic [guah_pkg::IN_GRP_W-1:0]  in_grp;

  assign in_grp   = in_tdata[guah_pkg::GRP_LSB +: guah_pkg::IN_GRP_W];
  assign grp_ok   = {1'b0, in_grp} < guah_pkg::GRP_LIMIT;
  assign in_fire  = in_tvalid && in_tready;
  assign hit      = (rd_data == addr_r);
  assign last     = (idx_r == guah_pkg::IDX_W'(guah_pkg::LIST_DEPTH - 1));
  assign out_free = !out_valid_r || out_tready;

  guah_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (tbl_cmd),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      guah_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == guah_pkg::OP_CLEAR || !grp_ok) begin
            state_nxt = guah_pkg::ST_FINISH;
          end else begin
            state_nxt = guah_pkg::ST_SCAN;
          end
        end
      end
      guah_pkg::ST_SCAN: begin
        if (hit || last) begin
          state_nxt = guah_pkg::ST_FINISH;
        end
      end
      guah_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = guah_pkg::ST_IDLE;
        end
      end
      default: state_nxt = guah_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    finish_fire = 1'b0;
    case (state_r)
      guah_pkg::ST_IDLE:   in_tready   = 1'b1;
      guah_pkg::ST_SCAN:   finish_fire = 1'b0;
      guah_pkg::ST_FINISH: finish_fire = out_free;
      default:             in_tready   = 1'b0;
    endcase
    tbl_cmd.shift = finish_fire && (stat_r == guah_pkg::STAT_ADDED);
    tbl_cmd.clear = finish_fire && (stat_r == guah_pkg::STAT_CLEARED);
    tbl_cmd.grp   = grp_r;
    tbl_cmd.idx   = idx_r;
    tbl_cmd.mask  = mask_r;
    tbl_cmd.addr  = addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= guah_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_tuser;
      grp_r  <= in_grp[guah_pkg::GIDX_W-1:0];
      addr_r <= in_tdata[guah_pkg::ADDR_LSB +: guah_pkg::ADDR_W];
      mask_r <= in_tdata[guah_pkg::MASK_LSB +: guah_pkg::GROUPS];
      idx_r  <= '0;
      if (in_tuser == guah_pkg::OP_CLEAR) begin
        stat_r <= guah_pkg::STAT_CLEARED;
      end else if (!grp_ok) begin
        stat_r <= guah_pkg::STAT_BAD_GROUP;
      end else begin
        stat_r <= guah_pkg::STAT_ADDED;
      end
    end else if (state_r == guah_pkg::ST_SCAN) begin
      if (hit) begin
        stat_r <= guah_pkg::STAT_PRESENT;
      end else if (!last) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      out_status_r <= stat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(guah_pkg::OUT_TDATA_W - guah_pkg::STATUS_W){1'b0}}, out_status_r};

  `GUAH_ASSERT(a_scan_is_insert,
               (state_r == guah_pkg::ST_SCAN) |-> (op_r == guah_pkg::OP_INSERT))
  `GUAH_ASSERT(a_write_at_finish,
               (tbl_cmd.shift || tbl_cmd.clear) |-> (state_r == guah_pkg::ST_FINISH && out_free))
  `GUAH_ASSERT(a_one_write_kind, !(tbl_cmd.shift && tbl_cmd.clear))
  `GUAH_ASSERT(a_finish_gives_result,
               finish_fire |=> (out_valid_r && state_r == guah_pkg::ST_IDLE))

endmodule
